@@ rtl/t8cpu_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// t8cpu_pkg
// Types and constants shared by the 8-bit toy processor step block.
// ----------------------------------------------------------------------------
package t8cpu_pkg;

   // sizes
   localparam int PROG_DEPTH_DEF = 128;
   localparam int NUM_REGS       = 4;
   localparam int DATA_DEPTH     = 8;
   localparam int REG_IDX_W      = $clog2(NUM_REGS);
   localparam int DATA_IDX_W     = $clog2(DATA_DEPTH);

   // item kinds
   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_STEP  = 1'b1;

   // instruction classes (top three bits)
   localparam logic [2:0] CLS_MOVE   = 3'b000;
   localparam logic [2:0] CLS_ARITH  = 3'b001;
   localparam logic [2:0] CLS_SHIFT  = 3'b010;
   localparam logic [2:0] CLS_CMP    = 3'b011;
   localparam logic [2:0] CLS_OUT    = 3'b100;
   localparam logic [2:0] CLS_BRZ    = 3'b101;
   localparam logic [2:0] CLS_BRA    = 3'b110;
   localparam logic [2:0] CLS_BAD    = 3'b111;

   // move sub-operations (bits 4:3)
   localparam logic [1:0] MV_LOAD  = 2'b00;
   localparam logic [1:0] MV_STORE = 2'b01;
   localparam logic [1:0] MV_COPY  = 2'b10;
   localparam logic [1:0] MV_IMM   = 2'b11;

   // emitted characters
   localparam logic [7:0] CHAR_E = 8'h45;
   localparam logic [7:0] CHAR_I = 8'h49;

   typedef struct packed {
      logic       kind;
      logic [6:0] prog_address;
      logic [7:0] prog_byte;
   } req_type;

   typedef struct packed {
      logic       out_valid;
      logic [7:0] out_byte;
      logic       bad_opcode;
      logic       halted;
      logic [7:0] next_pc;
      logic       zero_now;
   } rsp_type;

endpackage

@@ rtl/tiny_8bit_cpu_step_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tiny_8bit_cpu_step_top
// 8-bit toy processor: program store loader and single-instruction stepper.
//
//   channel | ports                            | moves
//   --------+----------------------------------+-----------------------------
//   request | req_valid, req_stall, req_data   | program byte write or step
//   result  | rsp_valid, rsp_stall, rsp_data   | one result per request
//
// One request is taken every cycle unless req_stall is high; its result
// appears in the result register in the cycle after the transfer. The rate
// is set by the execute logic between the prefetched instruction register
// and the result register. The program store is read ahead, registered, at
// the next program counter. Reset clears all state but the store array and
// read/result data; entries read as zero until written, one valid bit each.
// req_stall is high only while a result waits and rsp_stall is high.
// ----------------------------------------------------------------------------
module tiny_8bit_cpu_step_top #(
   parameter int PROG_DEPTH = t8cpu_pkg::PROG_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  t8cpu_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output t8cpu_pkg::rsp_type rsp_data
);

   localparam int         ADDR_W = $clog2(PROG_DEPTH);
   localparam logic [8:0] DEPTH9 = 9'(PROG_DEPTH);

   // architectural state
   logic [7:0]                            pc_ff, pc_in;
   logic                                  zero_ff, zero_in;
   logic [t8cpu_pkg::NUM_REGS-1:0][7:0]   regs_ff, regs_in;
   logic [t8cpu_pkg::DATA_DEPTH-1:0][7:0] dmem_ff, dmem_in;

   // program store and prefetch
   logic [7:0]            prog_mem_ff [PROG_DEPTH];
   logic [PROG_DEPTH-1:0] valid_ff;
   logic [7:0]            mem_rd_ff;
   logic                  vld_rd_ff;
   logic                  byp_hit_ff;
   logic [7:0]            byp_data_ff;

   // result register
   logic               rsp_valid_ff;
   t8cpu_pkg::rsp_type rsp_data_ff, rsp_in;

   logic              req_fire;
   logic              halted;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_idx;
   logic [ADDR_W-1:0] rd_idx;
   logic [7:0]        instr;
   logic [2:0]        cls;
   logic [t8cpu_pkg::REG_IDX_W-1:0]  x_idx, y_idx, a_idx, c_idx;
   logic [t8cpu_pkg::DATA_IDX_W-1:0] d_idx;
   logic [7:0]        arith;

   // handshake
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_fire  = req_valid & ~req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // instruction fields
   assign instr = byp_hit_ff ? byp_data_ff : (vld_rd_ff ? mem_rd_ff : 8'h00);
   assign cls   = instr[7:5];
   assign x_idx = instr[4:3];
   assign y_idx = instr[1:0];
   assign a_idx = instr[1:0];
   assign c_idx = instr[2:1];
   assign d_idx = instr[2:0];
   assign arith = instr[2] ? (regs_ff[x_idx] - regs_ff[y_idx])
                           : (regs_ff[x_idx] + regs_ff[y_idx]);

   assign halted = ({1'b0, pc_ff} >= DEPTH9);

   // program store write and next-pc read address
   assign wr_en  = req_fire & (req_data.kind == t8cpu_pkg::KIND_WRITE)
                 & ({2'b00, req_data.prog_address} < DEPTH9);
   assign wr_idx = ADDR_W'(req_data.prog_address);
   assign rd_idx = ({1'b0, pc_in} < DEPTH9) ? ADDR_W'(pc_in) : '0;

   // execute
   always_comb begin
      regs_in = regs_ff;
      dmem_in = dmem_ff;
      pc_in   = pc_ff;
      zero_in = zero_ff;
      rsp_in  = '0;
      rsp_in.halted = halted;
      if (req_fire && req_data.kind == t8cpu_pkg::KIND_STEP && !halted) begin
         pc_in = pc_ff + 8'd1;
         case (cls)
            t8cpu_pkg::CLS_MOVE: begin
               case (x_idx)
                  t8cpu_pkg::MV_LOAD:  regs_in[0] = dmem_ff[d_idx];
                  t8cpu_pkg::MV_STORE: dmem_in[d_idx] = regs_ff[0];
                  t8cpu_pkg::MV_COPY:  regs_in[a_idx] = regs_ff[c_idx];
                  default:             regs_in[0] = {5'b00000, instr[2:0]};
               endcase
               zero_in = (regs_in[0] == 8'h00);
            end
            t8cpu_pkg::CLS_ARITH: begin
               regs_in[x_idx] = arith;
               zero_in        = (arith == 8'h00);
            end
            t8cpu_pkg::CLS_SHIFT: begin
               regs_in[x_idx] = instr[2] ? {4'h0, regs_ff[x_idx][7:4]}
                                         : {regs_ff[x_idx][3:0], 4'h0};
            end
            t8cpu_pkg::CLS_CMP: begin
               zero_in = (regs_ff[x_idx] == regs_ff[y_idx]);
            end
            t8cpu_pkg::CLS_OUT: begin
               rsp_in.out_valid = 1'b1;
               rsp_in.out_byte  = instr[3] ? t8cpu_pkg::CHAR_I : regs_ff[a_idx];
            end
            t8cpu_pkg::CLS_BRZ: begin
               if (zero_ff) begin
                  pc_in = regs_ff[a_idx];
               end
            end
            t8cpu_pkg::CLS_BRA: begin
               pc_in = regs_ff[a_idx];
            end
            default: begin
               rsp_in.out_valid  = 1'b1;
               rsp_in.out_byte   = t8cpu_pkg::CHAR_E;
               rsp_in.bad_opcode = 1'b1;
            end
         endcase
      end
      rsp_in.next_pc  = pc_in;
      rsp_in.zero_now = zero_in;
   end

   // architectural state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff   <= '0;
         zero_ff <= 1'b0;
         regs_ff <= '0;
         dmem_ff <= '0;
      end else begin
         pc_ff   <= pc_in;
         zero_ff <= zero_in;
         regs_ff <= regs_in;
         dmem_ff <= dmem_in;
      end
   end

   // program store array with registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         prog_mem_ff[wr_idx] <= req_data.prog_byte;
      end
      mem_rd_ff   <= prog_mem_ff[rd_idx];
      byp_data_ff <= req_data.prog_byte;
   end

   // entry valid bits and write-to-fetch bypass
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         vld_rd_ff  <= 1'b0;
         byp_hit_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_idx] <= 1'b1;
         end
         vld_rd_ff  <= valid_ff[rd_idx];
         byp_hit_ff <= wr_en & (wr_idx == rd_idx);
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= rsp_in;
      end
   end

`ifndef SYNTHESIS
   // invalid class always reports the error character
   a_bad_emits_e : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.bad_opcode |->
         rsp_data_ff.out_valid && rsp_data_ff.out_byte == t8cpu_pkg::CHAR_E)
      else $error("bad opcode result without error character");

   // a halted result never leaves the counter inside the store
   a_halt_pc : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.halted |-> {1'b0, rsp_data_ff.next_pc} >= DEPTH9)
      else $error("halted result with counter inside program store");

   // a write transfer never emits a byte
   a_write_silent : assert property (@(posedge clock) disable iff (reset)
      req_fire && req_data.kind == t8cpu_pkg::KIND_WRITE |=>
         rsp_valid_ff && !rsp_data_ff.out_valid && !rsp_data_ff.bad_opcode)
      else $error("write transfer produced an output byte");
`endif

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 8-bit toy processor step block. Program bytes
// are loaded and stepped through the request channel. A cycle-free predictor
// of the processor state works out the expected response for each accepted
// transfer, and each response transfer is checked field by field against it.
// Random programs are steered away from the top of the store so that the
// block only halts in the last test.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int         IDLE_PCT     = 32;
   localparam int         HOLD_CYCLES  = 60;
   localparam int         RANDOM_ITEMS = 1500;
   localparam int         MAX_REPORTS  = 10;
   localparam int         PROG_LIMIT   = t8cpu_pkg::PROG_DEPTH_DEF;
   // turn-around point that keeps random programs below the end of the store
   localparam logic [6:0] SAFE_TURN    = 7'd124;

   // selector bit values inside an instruction byte
   localparam logic ALU_ADD  = 1'b0;
   localparam logic ALU_SUB  = 1'b1;
   localparam logic SH_LEFT  = 1'b0;
   localparam logic SH_RIGHT = 1'b1;
   localparam logic OUT_REG  = 1'b0;
   localparam logic OUT_CHAR = 1'b1;

   localparam logic [7:0] BRA_R0 = {t8cpu_pkg::CLS_BRA, 2'b00, 3'd0};

   logic               clock     = 1'b0;
   logic               reset     = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   t8cpu_pkg::req_type req_data  = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   t8cpu_pkg::rsp_type rsp_data;

   // predicted processor state
   logic [7:0] cpu_pc;
   logic [7:0] cpu_regs [t8cpu_pkg::NUM_REGS];
   logic       cpu_zero;
   logic [7:0] cpu_data [t8cpu_pkg::DATA_DEPTH];
   logic [7:0] cpu_prog [PROG_LIMIT];

   t8cpu_pkg::rsp_type pending_results [$];
   int                 fail_count = 0;
   logic               quiet      = 1'b0;
   logic               hold_go    = 1'b0;
   int                 hold_left  = 0;

   tiny_8bit_cpu_step_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #4 clock = ~clock;

   // expected response of one transfer, advancing the predicted state
   function automatic t8cpu_pkg::rsp_type cpu_execute(t8cpu_pkg::req_type it);
      t8cpu_pkg::rsp_type r;
      logic [7:0]         b;
      logic [2:0]         low3;
      logic [1:0]         rx;
      logic [1:0]         ry;
      r = '0;
      r.halted = (cpu_pc >= PROG_LIMIT);
      if (it.kind == t8cpu_pkg::KIND_WRITE) begin
         cpu_prog[it.prog_address] = it.prog_byte;
      end else if (!r.halted) begin
         b    = cpu_prog[cpu_pc[6:0]];
         rx   = b[4:3];
         ry   = b[1:0];
         low3 = b[2:0];
         cpu_pc = cpu_pc + 8'd1;
         case (b[7:5])
            t8cpu_pkg::CLS_MOVE: begin
               case (rx)
                  t8cpu_pkg::MV_LOAD:  cpu_regs[0] = cpu_data[low3];
                  t8cpu_pkg::MV_STORE: cpu_data[low3] = cpu_regs[0];
                  t8cpu_pkg::MV_COPY:  cpu_regs[low3[1:0]] = cpu_regs[b[2:1]];
                  default:             cpu_regs[0] = {5'd0, low3};
               endcase
               cpu_zero = (cpu_regs[0] == 8'd0);
            end
            t8cpu_pkg::CLS_ARITH: begin
               if (b[2] == ALU_SUB) cpu_regs[rx] = cpu_regs[rx] - cpu_regs[ry];
               else cpu_regs[rx] = cpu_regs[rx] + cpu_regs[ry];
               cpu_zero = (cpu_regs[rx] == 8'd0);
            end
            t8cpu_pkg::CLS_SHIFT: begin
               if (b[2] == SH_RIGHT) cpu_regs[rx] = cpu_regs[rx] >> 4;
               else cpu_regs[rx] = cpu_regs[rx] << 4;
            end
            t8cpu_pkg::CLS_CMP: cpu_zero = (cpu_regs[rx] == cpu_regs[ry]);
            t8cpu_pkg::CLS_OUT: begin
               r.out_valid = 1'b1;
               r.out_byte  = (b[3] == OUT_CHAR) ? t8cpu_pkg::CHAR_I : cpu_regs[ry];
            end
            t8cpu_pkg::CLS_BRZ: begin
               if (cpu_zero) cpu_pc = cpu_regs[ry];
            end
            t8cpu_pkg::CLS_BRA: cpu_pc = cpu_regs[ry];
            default: begin
               r.out_valid  = 1'b1;
               r.out_byte   = t8cpu_pkg::CHAR_E;
               r.bad_opcode = 1'b1;
            end
         endcase
      end
      r.next_pc  = cpu_pc;
      r.zero_now = cpu_zero;
      return r;
   endfunction

   // random byte that never branches
   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      do b = 8'($urandom);
      while (b[7:5] == t8cpu_pkg::CLS_BRA || b[7:5] == t8cpu_pkg::CLS_BRZ);
      return b;
   endfunction

   // one request transfer, with random idle cycles ahead of it
   task automatic send_item(input t8cpu_pkg::req_type it);
      while (!quiet && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_results.push_back(cpu_execute(it));
   endtask

   task automatic load_byte(input logic [6:0] addr, input logic [7:0] data);
      send_item({t8cpu_pkg::KIND_WRITE, addr, data});
   endtask

   // step item; the unused fields carry noise
   task automatic step_item();
      send_item({t8cpu_pkg::KIND_STEP, 7'($urandom), 8'($urandom)});
   endtask

   // step that never lets the counter climb past the turn-around pair
   task automatic step_safe();
      logic [7:0] b;
      logic [7:0] dest;
      b = cpu_prog[cpu_pc[6:0]];
      if (cpu_pc == SAFE_TURN) begin
         load_byte(SAFE_TURN,
                   {t8cpu_pkg::CLS_MOVE, t8cpu_pkg::MV_IMM, 3'($urandom_range(7))});
         load_byte(SAFE_TURN + 7'd1, BRA_R0);
      end else if (cpu_pc == SAFE_TURN + 7'd1) begin
         // r0 still holds the small immediate from the turn-around
         if (b != BRA_R0) load_byte(SAFE_TURN + 7'd1, BRA_R0);
      end else begin
         dest = cpu_pc + 8'd1;
         if (b[7:5] == t8cpu_pkg::CLS_BRA || (b[7:5] == t8cpu_pkg::CLS_BRZ && cpu_zero))
            dest = cpu_regs[b[1:0]];
         if (dest > SAFE_TURN) load_byte(cpu_pc[6:0], plain_byte());
      end
      step_item();
   endtask

   // every class and sub-operation, masking, wrap on subtract, both branch outcomes
   task automatic test_directed_ops();
      logic [7:0] prog [17];
      prog = '{
         {t8cpu_pkg::CLS_MOVE, t8cpu_pkg::MV_IMM, 3'd7},     // r0 = 7
         {t8cpu_pkg::CLS_MOVE, t8cpu_pkg::MV_STORE, 3'd5},   // data[5] = 7
         {t8cpu_pkg::CLS_MOVE, t8cpu_pkg::MV_COPY, 3'b001},  // r1 = r0
         {t8cpu_pkg::CLS_ARITH, 2'd3, ALU_SUB, 2'd0},        // r3 = 0 - 7, wraps
         {t8cpu_pkg::CLS_SHIFT, 2'd3, SH_LEFT, 2'd0},        // r3 << 4
         {t8cpu_pkg::CLS_SHIFT, 2'd3, SH_RIGHT, 2'd0},       // r3 >> 4
         {t8cpu_pkg::CLS_ARITH, 2'd1, ALU_ADD, 2'd3},        // r1 += r3
         {t8cpu_pkg::CLS_OUT, 1'b0, OUT_REG, 3'd7},          // index 7 masked to r3
         {t8cpu_pkg::CLS_OUT, 1'b1, OUT_CHAR, 3'd7},         // emits 'I'
         8'hFF,                                              // invalid class
         {t8cpu_pkg::CLS_MOVE, t8cpu_pkg::MV_LOAD, 3'd5},    // r0 = data[5], flag clear
         {t8cpu_pkg::CLS_BRZ, 2'd0, 3'd0},                   // not taken
         {t8cpu_pkg::CLS_CMP, 2'd0, 1'b0, 2'd0},             // flag set
         {t8cpu_pkg::CLS_BRZ, 2'd0, 3'd5},                   // taken to r1 = 16
         8'h00, 8'h00,
         {t8cpu_pkg::CLS_BRA, 2'b11, 3'd2}                   // back to r2 = 0
      };
      foreach (prog[n]) begin
         if (n < 14 || n == 16) load_byte(7'(n), prog[n]);
      end
      repeat (15) step_item();
   endtask

   // receiver holds off while the sender keeps offering transfers
   task automatic test_back_pressure();
      int n;
      quiet   = 1'b1;
      hold_go = 1'b1;
      for (n = 0; n < 40; n++) begin
         if (n % 4 == 0) load_byte(cpu_pc[6:0] + 7'($urandom_range(3)), 8'($urandom));
         else step_safe();
      end
      quiet = 1'b0;
   endtask

   // random programs written around the counter and stepped through
   task automatic test_random_program();
      int         n;
      logic [6:0] addr;
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         // one stretch with no idling on either side
         quiet = (n >= 600 && n < 800);
         if ($urandom_range(99) < 25) begin
            if ($urandom_range(1) == 0) addr = cpu_pc[6:0] + 7'($urandom_range(7));
            else addr = 7'($urandom);
            load_byte(addr, 8'($urandom));
         end else begin
            step_safe();
         end
      end
      quiet = 1'b0;
   endtask

   // run off the end of the store, then poke at the halted block
   task automatic test_halt();
      logic [7:0] seq [7];
      int n;
      seq = '{
         {t8cpu_pkg::CLS_MOVE, t8cpu_pkg::MV_IMM, 3'd1},     // r0 = 1
         {t8cpu_pkg::CLS_MOVE, t8cpu_pkg::MV_COPY, 3'b001},  // r1 = 1
         {t8cpu_pkg::CLS_MOVE, t8cpu_pkg::MV_IMM, 3'd4},     // r0 = 4
         {t8cpu_pkg::CLS_SHIFT, 2'd0, SH_LEFT, 2'd0},        // r0 = 0x40
         {t8cpu_pkg::CLS_ARITH, 2'd0, ALU_ADD, 2'd0},        // r0 = 0x80
         {t8cpu_pkg::CLS_ARITH, 2'd0, ALU_SUB, 2'd1},        // r0 = 0x7f
         BRA_R0                                              // jump to the last entry
      };
      // walk back to address zero
      while (cpu_pc != 8'd0) begin
         if (cpu_pc == SAFE_TURN + 7'd1) begin
            step_safe();
         end else begin
            load_byte(cpu_pc[6:0], {t8cpu_pkg::CLS_MOVE, t8cpu_pkg::MV_IMM, 3'd0});
            load_byte(cpu_pc[6:0] + 7'd1, BRA_R0);
            step_item();
            step_item();
         end
      end
      foreach (seq[i]) load_byte(7'(i), seq[i]);
      load_byte(7'd127, {t8cpu_pkg::CLS_CMP, 5'd0});
      repeat (8) step_item();
      // halted: steps do nothing, writes still land in the store
      for (n = 0; n < 12; n++) begin
         if (n % 2 == 1) step_item();
         else load_byte(7'($urandom), 8'($urandom));
      end
   endtask

   // result side stall: long hold-off on request, none while quiet, else random
   always @(posedge clock) begin
      if (hold_go) begin
         hold_go   = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (quiet) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < IDLE_PCT);
      end
   end

   // compare each response transfer with the oldest expectation
   always @(posedge clock) begin
      t8cpu_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            if (fail_count < MAX_REPORTS)
               $display("unexpected response: %p", rsp_data);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.out_valid  !== want.out_valid  ||
                rsp_data.out_byte   !== want.out_byte   ||
                rsp_data.bad_opcode !== want.bad_opcode ||
                rsp_data.halted     !== want.halted     ||
                rsp_data.next_pc    !== want.next_pc    ||
                rsp_data.zero_now   !== want.zero_now) begin
               if (fail_count < MAX_REPORTS) begin
                  $write("mismatch at %0t: exp out=%0b/%02h bad=%0b halt=%0b pc=%02h z=%0b",
                         $realtime, want.out_valid, want.out_byte, want.bad_opcode,
                         want.halted, want.next_pc, want.zero_now);
                  $display(", got out=%0b/%02h bad=%0b halt=%0b pc=%02h z=%0b",
                           rsp_data.out_valid, rsp_data.out_byte, rsp_data.bad_opcode,
                           rsp_data.halted, rsp_data.next_pc, rsp_data.zero_now);
               end
               fail_count++;
            end
         end
      end
   end

   // run limit
   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      cpu_pc   = 8'd0;
      cpu_zero = 1'b0;
      foreach (cpu_regs[i]) cpu_regs[i] = 8'd0;
      foreach (cpu_data[i]) cpu_data[i] = 8'd0;
      foreach (cpu_prog[i]) cpu_prog[i] = 8'd0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_directed_ops();
      test_back_pressure();
      test_random_program();
      test_halt();

      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule

@@ files.f @@
rtl/t8cpu_pkg.sv
rtl/tiny_8bit_cpu_step_top.sv
tb/sv/tb_top.sv
